FILE: sv/vctp_pkg.sv
package vctp_pkg;

    // Tracking and configuration constants
    localparam int unsigned TIE_EPSILON = 3;
    localparam logic [15:0] MAX_DISTANCE_RESET = 16'd300;
    localparam logic signed [15:0] MIN_COSINE_RESET = 16'sd22938;

    // Configuration register indexes
    typedef enum logic {
        REG_MAX_DISTANCE = 1'b0,
        REG_MIN_COSINE   = 1'b1
    } cfg_reg_t;

    // Queue between classifier and evaluator
    localparam int unsigned FIFO_DEPTH = 2;
    localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // Iterative units
    localparam int unsigned SQRT_STEPS = 24;
    localparam int unsigned SQRT_IN_W  = 2 * SQRT_STEPS;
    localparam int unsigned SQRT_REM_W = SQRT_STEPS + 3;
    localparam int unsigned DIV_STEPS  = 16;
    localparam int unsigned STEP_CNT_W = $clog2(SQRT_STEPS);

    // One classified candidate request
    typedef struct packed {
        logic        qual;
        logic        last;
        logic [15:0] id;
        logic [31:0] dist_sq;
        logic [31:0] fwd_sq;
        logic        dot_neg;
        logic [31:0] dot_mag;
    } cand_t;

    // Digit-by-digit square root state
    typedef struct packed {
        logic [SQRT_IN_W-1:0]  val;
        logic [SQRT_REM_W-1:0] rem;
        logic [SQRT_STEPS-1:0] root;
    } sqrt_t;

    // Retire one root bit: bring in two radicand bits, try subtracting 4r+1
    function automatic sqrt_t sqrt_step(input sqrt_t cur);
        sqrt_t                 nxt;
        logic [SQRT_REM_W-1:0] shifted;
        logic [SQRT_REM_W-1:0] trial;
        logic                  ge;
        shifted  = {cur.rem[SQRT_REM_W-3:0], cur.val[SQRT_IN_W-1 -: 2]};
        trial    = {1'b0, cur.root, 2'b01};
        ge       = (shifted >= trial);
        nxt.val  = {cur.val[SQRT_IN_W-3:0], 2'b00};
        nxt.rem  = ge ? (shifted - trial) : shifted;
        nxt.root = {cur.root[SQRT_STEPS-2:0], ge};
        return nxt;
    endfunction

endpackage

FILE: sv/vctp_front.sv
module vctp_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic signed [20:0]    view_x,
    input  logic signed [20:0]    view_y,
    input  logic signed [20:0]    view_z,
    input  logic signed [15:0]    fwd_x,
    input  logic signed [15:0]    fwd_y,
    input  logic signed [15:0]    fwd_z,
    input  logic signed [20:0]    target_x,
    input  logic signed [20:0]    target_y,
    input  logic signed [20:0]    target_z,
    input  logic [15:0]           target_id,
    input  logic                  eligible,
    input  logic                  last,
    input  logic [31:0]           max_dist_sq,
    output logic                  push,
    output vctp_pkg::cand_t       push_data,
    input  logic                  fifo_full
);
    import vctp_pkg::*;

    logic a_valid_reg;
    logic b_valid_reg;
    logic en;

    logic signed [21:0] dx_reg, dy_reg, dz_reg;
    logic signed [15:0] fx_reg, fy_reg, fz_reg;
    logic [15:0]        id_a_reg, id_b_reg;
    logic               elig_a_reg, elig_b_reg;
    logic               last_a_reg, last_b_reg;

    logic signed [43:0] sq_dx_reg, sq_dy_reg, sq_dz_reg;
    logic signed [31:0] sq_fx_reg, sq_fy_reg, sq_fz_reg;
    logic signed [37:0] dot_x_reg, dot_y_reg, dot_z_reg;

    logic [45:0]        dist_full;
    logic [31:0]        fwd_sq;
    logic signed [39:0] dot_sum;
    logic [39:0]        dot_mag;

    // Advance the pipe unless the last stage is stuck on a full queue
    assign en       = !b_valid_reg || !fifo_full;
    assign in_ready = !a_valid_reg || en;
    assign push     = b_valid_reg && !fifo_full;

    // Stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                a_valid_reg <= in_valid;
            end
            if (en)
            begin
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    // Capture request and form offsets
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            dx_reg     <= {target_x[20], target_x} - {view_x[20], view_x};
            dy_reg     <= {target_y[20], target_y} - {view_y[20], view_y};
            dz_reg     <= {target_z[20], target_z} - {view_z[20], view_z};
            fx_reg     <= fwd_x;
            fy_reg     <= fwd_y;
            fz_reg     <= fwd_z;
            id_a_reg   <= target_id;
            elig_a_reg <= eligible;
            last_a_reg <= last;
        end
    end

    // Form all products in parallel
    always_ff @(posedge clk)
    begin
        if (en && a_valid_reg)
        begin
            sq_dx_reg  <= dx_reg * dx_reg;
            sq_dy_reg  <= dy_reg * dy_reg;
            sq_dz_reg  <= dz_reg * dz_reg;
            sq_fx_reg  <= fx_reg * fx_reg;
            sq_fy_reg  <= fy_reg * fy_reg;
            sq_fz_reg  <= fz_reg * fz_reg;
            dot_x_reg  <= fx_reg * dx_reg;
            dot_y_reg  <= fy_reg * dy_reg;
            dot_z_reg  <= fz_reg * dz_reg;
            id_b_reg   <= id_a_reg;
            elig_b_reg <= elig_a_reg;
            last_b_reg <= last_a_reg;
        end
    end

    // Sum and classify
    always_comb
    begin
        dist_full = 46'(unsigned'(sq_dx_reg)) + 46'(unsigned'(sq_dy_reg))
                  + 46'(unsigned'(sq_dz_reg));
        fwd_sq    = unsigned'(sq_fx_reg) + unsigned'(sq_fy_reg) + unsigned'(sq_fz_reg);
        dot_sum   = 40'(dot_x_reg) + 40'(dot_y_reg) + 40'(dot_z_reg);
        dot_mag   = dot_sum[39] ? unsigned'(-dot_sum) : unsigned'(dot_sum);

        push_data.qual    = elig_b_reg && (max_dist_sq != 32'd0) && (dist_full != 46'd0)
                          && (dist_full <= {14'd0, max_dist_sq}) && (fwd_sq != 32'd0);
        push_data.last    = last_b_reg;
        push_data.id      = id_b_reg;
        push_data.dist_sq = dist_full[31:0];
        push_data.fwd_sq  = fwd_sq;
        push_data.dot_neg = dot_sum[39];
        push_data.dot_mag = dot_mag[31:0];
    end

endmodule

FILE: sv/vctp_fifo.sv
module vctp_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  vctp_pkg::cand_t wdata,
    output logic            full,
    input  logic            pop,
    output vctp_pkg::cand_t rdata,
    output logic            empty
);
    import vctp_pkg::*;

    cand_t                 slot_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_CNT_W-1:0] count_reg;

    assign full  = (count_reg == FIFO_CNT_W'(FIFO_DEPTH));
    assign empty = (count_reg == '0);
    assign rdata = slot_reg[rd_ptr_reg];

    // Pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0
                                                                          : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0
                                                                          : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Store entries
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

FILE: sv/vctp_back.sv
module vctp_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  empty,
    input  vctp_pkg::cand_t       rdata,
    output logic                  pop,
    input  logic signed [15:0]    min_cos,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  found,
    output logic [15:0]           best_id,
    output logic signed [15:0]    best_cosine,
    output logic [31:0]           best_distance_sq
);
    import vctp_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQRT,
        S_MUL,
        S_DIV,
        S_PICK,
        S_EMIT
    } state_t;

    state_t                 state_reg;
    logic [STEP_CNT_W-1:0]  cnt_reg;
    logic                   out_valid_reg;
    logic                   found_reg;
    logic [15:0]            out_id_reg;
    logic signed [15:0]     out_cos_reg;
    logic [31:0]            out_dist_reg;
    logic                   have_best_reg;
    logic signed [15:0]     best_cos_reg;
    logic [31:0]            best_dist_reg;
    logic [15:0]            best_id_reg;

    logic                   last_reg;
    logic [15:0]            id_reg;
    logic [31:0]            dist_reg;
    logic                   neg_reg;
    logic [31:0]            mag_reg;
    sqrt_t                  sq_f_reg;
    sqrt_t                  sq_d_reg;
    logic [39:0]            div_reg;
    logic [40:0]            rem_reg;
    logic [15:0]            q_reg;
    logic                   ovf_reg;

    logic [40:0]            rem_shift;
    logic                   rem_ge;
    logic signed [15:0]     cos_val;
    logic signed [16:0]     diff;
    logic signed [16:0]     diff_abs;
    logic                   take;

    localparam logic signed [16:0] EPS = 17'(TIE_EPSILON);

    assign pop              = (state_reg == S_IDLE) && !empty;
    assign out_valid        = out_valid_reg;
    assign found            = found_reg;
    assign best_id          = out_id_reg;
    assign best_cosine      = out_cos_reg;
    assign best_distance_sq = out_dist_reg;

    // Restoring divide step
    assign rem_shift = {rem_reg[39:0], 1'b0};
    assign rem_ge    = (rem_shift >= {1'b0, div_reg});

    // Saturate cosine and judge against the kept candidate
    always_comb
    begin
        if (!neg_reg)
        begin
            cos_val = (ovf_reg || q_reg >= 16'd32767) ? 16'sh7FFF : signed'(q_reg);
        end
        else
        begin
            cos_val = (ovf_reg || q_reg >= 16'd32768) ? 16'sh8000 : signed'(-q_reg);
        end
        diff     = {cos_val[15], cos_val} - {best_cos_reg[15], best_cos_reg};
        diff_abs = diff[16] ? -diff : diff;
        take     = (cos_val >= min_cos)
                && (!have_best_reg || diff > EPS
                    || (diff_abs <= EPS && dist_reg < best_dist_reg));
    end

    // Sequencer, tracking and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
            out_id_reg    <= '0;
            out_cos_reg   <= '0;
            out_dist_reg  <= '0;
            have_best_reg <= 1'b0;
            best_cos_reg  <= 16'sh8000;
            best_dist_reg <= '1;
            best_id_reg   <= '0;
        end
        else
        begin
            if (out_valid_reg && out_ready && (state_reg != S_EMIT))
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    cnt_reg <= '0;
                    if (!empty)
                    begin
                        if (rdata.qual)
                        begin
                            state_reg <= S_SQRT;
                        end
                        else if (rdata.last)
                        begin
                            state_reg <= S_EMIT;
                        end
                    end
                end
                S_SQRT:
                begin
                    if (cnt_reg == STEP_CNT_W'(SQRT_STEPS - 1))
                    begin
                        cnt_reg   <= '0;
                        state_reg <= S_MUL;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                S_MUL:
                begin
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (cnt_reg == STEP_CNT_W'(DIV_STEPS - 1))
                    begin
                        cnt_reg   <= '0;
                        state_reg <= S_PICK;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                S_PICK:
                begin
                    if (take)
                    begin
                        have_best_reg <= 1'b1;
                        best_cos_reg  <= cos_val;
                        best_dist_reg <= dist_reg;
                        best_id_reg   <= id_reg;
                    end
                    state_reg <= last_reg ? S_EMIT : S_IDLE;
                end
                S_EMIT:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        found_reg     <= have_best_reg;
                        out_id_reg    <= have_best_reg ? best_id_reg : 16'd0;
                        out_cos_reg   <= have_best_reg ? best_cos_reg : 16'sd0;
                        out_dist_reg  <= have_best_reg ? best_dist_reg : 32'd0;
                        have_best_reg <= 1'b0;
                        best_cos_reg  <= 16'sh8000;
                        best_dist_reg <= '1;
                        best_id_reg   <= '0;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Datapath: latch request, root both norms, multiply, divide
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (!empty)
                begin
                    last_reg <= rdata.last;
                    id_reg   <= rdata.id;
                    dist_reg <= rdata.dist_sq;
                    neg_reg  <= rdata.dot_neg;
                    mag_reg  <= rdata.dot_mag;
                    sq_f_reg <= '{val: {16'd0, rdata.fwd_sq}, rem: '0, root: '0};
                    sq_d_reg <= '{val: {rdata.dist_sq, 16'd0}, rem: '0, root: '0};
                end
            end
            S_SQRT:
            begin
                sq_f_reg <= sqrt_step(sq_f_reg);
                sq_d_reg <= sqrt_step(sq_d_reg);
            end
            S_MUL:
            begin
                div_reg <= sq_f_reg.root[15:0] * sq_d_reg.root;
                rem_reg <= {2'b00, mag_reg, 7'd0};
                q_reg   <= '0;
            end
            S_DIV:
            begin
                ovf_reg <= ({1'b0, mag_reg, 7'd0} >= div_reg);
                rem_reg <= rem_ge ? (rem_shift - {1'b0, div_reg}) : rem_shift;
                q_reg   <= {q_reg[14:0], rem_ge};
            end
            default:
            begin
            end
        endcase
    end

endmodule

FILE: sv/view_cone_target_picker.sv
// Flow: a candidate is classified through front stages A (offsets) and B (products) and queued;
// the evaluator pops it while idle, and one that passes the range checks then takes 24 square-root
// steps, 1 multiply, 16 divide steps and 1 compare; a last candidate then goes to the emit state,
// which loads the result register. The evaluator takes no new candidate until it is back in idle;
// a rejected candidate is popped without entering the root/divide sequence.
// Reset: async active low; max_distance = 300, min_cosine = 22938, tracking cleared.
module view_cone_target_picker (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic                  cfg_addr,
    input  logic [15:0]           cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic signed [20:0]    view_x,
    input  logic signed [20:0]    view_y,
    input  logic signed [20:0]    view_z,
    input  logic signed [15:0]    fwd_x,
    input  logic signed [15:0]    fwd_y,
    input  logic signed [15:0]    fwd_z,
    input  logic signed [20:0]    target_x,
    input  logic signed [20:0]    target_y,
    input  logic signed [20:0]    target_z,
    input  logic [15:0]           target_id,
    input  logic                  eligible,
    input  logic                  last,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  found,
    output logic [15:0]           best_id,
    output logic signed [15:0]    best_cosine,
    output logic [31:0]           best_distance_sq
);
    import vctp_pkg::*;

    logic [15:0]        max_distance_reg;
    logic signed [15:0] min_cosine_reg;
    logic [31:0]        max_dist_sq_reg;
    logic               push;
    logic               pop;
    logic               fifo_full;
    logic               fifo_empty;
    cand_t              push_data;
    cand_t              pop_data;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_distance_reg <= MAX_DISTANCE_RESET;
            min_cosine_reg   <= MIN_COSINE_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_MAX_DISTANCE: max_distance_reg <= cfg_data;
                REG_MIN_COSINE:   min_cosine_reg   <= signed'(cfg_data);
                default:          max_distance_reg <= max_distance_reg;
            endcase
        end
    end

    // Square the range limit once
    always_ff @(posedge clk)
    begin
        max_dist_sq_reg <= max_distance_reg * max_distance_reg;
    end

    vctp_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .view_x      (view_x),
        .view_y      (view_y),
        .view_z      (view_z),
        .fwd_x       (fwd_x),
        .fwd_y       (fwd_y),
        .fwd_z       (fwd_z),
        .target_x    (target_x),
        .target_y    (target_y),
        .target_z    (target_z),
        .target_id   (target_id),
        .eligible    (eligible),
        .last        (last),
        .max_dist_sq (max_dist_sq_reg),
        .push        (push),
        .push_data   (push_data),
        .fifo_full   (fifo_full)
    );

    vctp_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (push_data),
        .full  (fifo_full),
        .pop   (pop),
        .rdata (pop_data),
        .empty (fifo_empty)
    );

    vctp_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .empty            (fifo_empty),
        .rdata            (pop_data),
        .pop              (pop),
        .min_cos          (min_cosine_reg),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .found            (found),
        .best_id          (best_id),
        .best_cosine      (best_cosine),
        .best_distance_sq (best_distance_sq)
    );

endmodule

FILE: tb/testbench.sv
module testbench;
    import vctp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TIE_EPS = 3;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic signed [20:0] vx, vy, vz;
        logic signed [15:0] fx, fy, fz;
        logic signed [20:0] tx, ty, tz;
        logic [15:0]        id;
        logic               elig;
        logic               lst;
    } cand_req_t;

    typedef struct packed {
        logic               found;
        logic [15:0]        id;
        logic signed [15:0] cosv;
        logic [31:0]        dist_sq;
    } pick_t;

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic cfg_addr;
    logic [15:0] cfg_data;
    logic in_valid;
    logic in_ready;
    logic signed [20:0] view_x, view_y, view_z;
    logic signed [15:0] fwd_x, fwd_y, fwd_z;
    logic signed [20:0] target_x, target_y, target_z;
    logic [15:0] target_id;
    logic eligible;
    logic last;
    logic out_valid;
    logic out_ready;
    logic found;
    logic [15:0] best_id;
    logic signed [15:0] best_cosine;
    logic [31:0] best_distance_sq;

    view_cone_target_picker u_top (.*);

    // Pending requests and expected picks
    cand_req_t pending_q[$];
    pick_t     pick_q[$];
    int        fail_count;
    int        accepted_count;
    int        cycle_count;
    bit        hold_sink;
    bit        stim_done;

    // Predictor state
    logic [15:0]        p_max_dist;
    logic signed [15:0] p_min_cos;
    bit                 p_have;
    int                 p_cos;
    longint unsigned    p_dist;
    logic [15:0]        p_id;

    always begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic void clear_pick();
        p_have = 0;
        p_cos  = -32768;
        p_dist = 64'hFFFF_FFFF;
        p_id   = '0;
    endfunction

    // Advance the predictor by one candidate; push a pick on last
    function automatic void predict_pick(cand_req_t c);
        longint dx, dy, dz, dot;
        longint unsigned s, f, nf, nd, mag, q, maxsq;
        int cv, diff, adiff;
        pick_t p;
        dx = longint'(c.tx) - longint'(c.vx);
        dy = longint'(c.ty) - longint'(c.vy);
        dz = longint'(c.tz) - longint'(c.vz);
        s = dx * dx + dy * dy + dz * dz;
        f = longint'(c.fx) * c.fx + longint'(c.fy) * c.fy + longint'(c.fz) * c.fz;
        maxsq = longint'(p_max_dist) * p_max_dist;
        if (c.elig && p_max_dist != 0 && s != 0 && s <= maxsq && f != 0) begin
            dot = c.fx * dx + c.fy * dy + c.fz * dz;
            nf = int_sqrt(f);
            nd = int_sqrt(s << 16);
            mag = (dot < 0) ? -dot : dot;
            q = (mag << 23) / (nf * nd);
            if (dot < 0) cv = (q >= 32768) ? -32768 : -int'(q);
            else cv = (q >= 32767) ? 32767 : int'(q);
            if (cv >= p_min_cos) begin
                diff = cv - p_cos;
                adiff = diff < 0 ? -diff : diff;
                if (!p_have || diff > TIE_EPS || (adiff <= TIE_EPS && s < p_dist)) begin
                    p_have = 1;
                    p_cos = cv;
                    p_dist = s;
                    p_id = c.id;
                end
            end
        end
        if (c.lst) begin
            if (p_have) p = '{1'b1, p_id, 16'(p_cos), 32'(p_dist)};
            else p = '0;
            pick_q.push_back(p);
            clear_pick();
        end
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] exp);
        $display("MISMATCH %s: got %0h expected %0h", what, got, exp);
        fail_count++;
    endtask

    // Driver: offer pending requests with random gaps
    int gap_cnt;
    always @(posedge clk or negedge rst_n) begin
        cand_req_t c;
        if (!rst_n) begin
            in_valid <= 1'b0;
            gap_cnt  <= 0;
        end
        else begin
            if (in_valid && in_ready) accepted_count <= accepted_count + 1;
            if (in_valid && !in_ready) begin
                // hold
            end
            else if (gap_cnt > 0) begin
                in_valid <= 1'b0;
                gap_cnt  <= gap_cnt - 1;
            end
            else if (pending_q.size() > 0) begin
                c = pending_q.pop_front();
                predict_pick(c);
                in_valid <= 1'b1;
                {view_x, view_y, view_z} <= {c.vx, c.vy, c.vz};
                {fwd_x, fwd_y, fwd_z} <= {c.fx, c.fy, c.fz};
                {target_x, target_y, target_z} <= {c.tx, c.ty, c.tz};
                target_id <= c.id;
                eligible  <= c.elig;
                last      <= c.lst;
                gap_cnt   <= ($urandom_range(0, 9) < 6) ? 0 :
                             ($urandom_range(0, 9) < 8) ? $urandom_range(1, 4)
                                                        : $urandom_range(20, 120);
            end
            else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Monitor: random stalls on the result side and compare
    always @(posedge clk or negedge rst_n) begin
        pick_t e;
        int r;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end
        else begin
            if (out_valid && out_ready) begin
                if (pick_q.size() == 0) begin
                    $display("MISMATCH unexpected result id %0h", best_id);
                    fail_count++;
                end
                else begin
                    e = pick_q.pop_front();
                    if (found !== e.found) report("found", 32'(found), 32'(e.found));
                    if (best_id !== e.id) report("best_id", 32'(best_id), 32'(e.id));
                    if (best_cosine !== e.cosv)
                        report("best_cosine", 32'(best_cosine), 32'(e.cosv));
                    if (best_distance_sq !== e.dist_sq)
                        report("best_distance_sq", best_distance_sq, e.dist_sq);
                end
            end
            r = $urandom_range(0, 99);
            if (hold_sink) out_ready <= 1'b0;
            else if (r < 70) out_ready <= 1'b1;
            else if (r < 97) out_ready <= 1'b0;
            else out_ready <= ($urandom_range(0, 1) == 0);
        end
    end

    // Watchdog
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Hold the sink off for a long stretch during the random part
    initial begin
        hold_sink = 0;
        wait (accepted_count > 100);
        hold_sink = 1;
        repeat (600) @(posedge clk);
        hold_sink = 0;
    end

    function automatic cand_req_t rand_req(bit near);
        cand_req_t c;
        int span;
        c.vx = 21'($urandom); c.vy = 21'($urandom); c.vz = 21'($urandom);
        c.fx = 16'($urandom); c.fy = 16'($urandom); c.fz = 16'($urandom);
        if (near) begin
            span = ($urandom_range(0, 9) == 0) ? 40000 : 400;
            c.tx = 21'(c.vx + $signed($urandom_range(0, 2 * span)) - span);
            c.ty = 21'(c.vy + $signed($urandom_range(0, 2 * span)) - span);
            c.tz = 21'(c.vz + $signed($urandom_range(0, 2 * span)) - span);
            // aim the view roughly at the target half the time
            if ($urandom_range(0, 1)) begin
                c.fx = 16'(32'(c.tx - c.vx) * 40 + $signed($urandom_range(0, 200)) - 100);
                c.fy = 16'(32'(c.ty - c.vy) * 40 + $signed($urandom_range(0, 200)) - 100);
                c.fz = 16'(32'(c.tz - c.vz) * 40 + $signed($urandom_range(0, 200)) - 100);
            end
        end
        else begin
            c.tx = 21'($urandom); c.ty = 21'($urandom); c.tz = 21'($urandom);
        end
        c.id   = 16'($urandom);
        c.elig = ($urandom_range(0, 9) != 0);
        c.lst  = 1'b0;
        return c;
    endfunction

    task automatic write_reg(cfg_reg_t idx, logic [15:0] val);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_data  <= val;
        if (idx == REG_MAX_DISTANCE) p_max_dist = val;
        else p_min_cos = val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic drain();
        wait (pending_q.size() == 0 && !in_valid && pick_q.size() == 0);
        repeat (80) @(posedge clk);
    endtask

    task automatic directed_scan();
        cand_req_t c;
        c = '0;
        // a tie pair, then coincident point, zero direction and ineligible
        c.fx = 16'sd32767; c.tx = 21'sd100; c.id = 16'h1111; c.elig = 1;
        pending_q.push_back(c);
        c.tx = 21'sd50; c.id = 16'h2222;
        pending_q.push_back(c);
        c.tx = 21'sd0; c.id = 16'h3333;
        pending_q.push_back(c);
        c.tx = 21'sd40; c.fx = 0; c.id = 16'h4444;
        pending_q.push_back(c);
        c.fx = -16'sd32768; c.tx = -21'sd30; c.elig = 0; c.id = 16'hFFFF;
        pending_q.push_back(c);
        c.elig = 1; c.lst = 1; c.id = 16'h5555;
        pending_q.push_back(c);
        // extremes of positions and a scan with nothing qualifying
        c = '0;
        c.vx = -21'sd1048576; c.vy = 21'sd1048575; c.vz = -21'sd1048576;
        c.tx = 21'sd1048575; c.ty = -21'sd1048576; c.tz = 21'sd1048575;
        c.fx = -16'sd32768; c.fy = -16'sd32768; c.fz = 16'sd32767;
        c.elig = 1; c.lst = 1; c.id = 16'hFFFF;
        pending_q.push_back(c);
    endtask

    task automatic random_scans(int n_items);
        cand_req_t c;
        int i;
        for (i = 0; i < n_items; i++) begin
            c = rand_req($urandom_range(0, 9) < 8);
            c.lst = ($urandom_range(0, 5) == 0) || (i == n_items - 1);
            pending_q.push_back(c);
        end
    endtask

    initial begin
        rst_n = 1'b0;
        cfg_wr_en = 1'b0; cfg_addr = 1'b0; cfg_data = '0;
        view_x = '0; view_y = '0; view_z = '0;
        fwd_x = '0; fwd_y = '0; fwd_z = '0;
        target_x = '0; target_y = '0; target_z = '0;
        target_id = '0; eligible = 1'b0; last = 1'b0;
        fail_count = 0; accepted_count = 0; cycle_count = 0;
        p_max_dist = MAX_DISTANCE_RESET;
        p_min_cos  = MIN_COSINE_RESET;
        clear_pick();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        directed_scan();
        random_scans(120);
        drain();
        write_reg(REG_MAX_DISTANCE, 16'hFFFF);
        write_reg(REG_MIN_COSINE, 16'h8000);
        directed_scan();
        random_scans(150);
        drain();
        write_reg(REG_MAX_DISTANCE, 16'd0);
        random_scans(20);
        drain();
        write_reg(REG_MAX_DISTANCE, 16'd1);
        write_reg(REG_MIN_COSINE, 16'h7FFF);
        random_scans(30);
        drain();
        write_reg(REG_MAX_DISTANCE, 16'd500);
        write_reg(REG_MIN_COSINE, 16'd0);
        random_scans(200);
        drain();

        if (fail_count == 0) $display("Test completed successfully");
        else $display("Test completed with failures");
        $finish;
    end

endmodule

FILE: filelist.f
sv/vctp_pkg.sv
sv/vctp_front.sv
sv/vctp_fifo.sv
sv/vctp_back.sv
sv/view_cone_target_picker.sv
tb/testbench.sv
